// File: rtl/core/strc_pkg.sv
// Shared types and constants for the stepper trigger run-out controller.
package strc_pkg;

  localparam int QUOT_W      = 11;     // half period and run-out length width
  localparam int MS_W        = 16;     // millisecond counters and limits
  localparam int SPEED_SPAN  = 1950;   // half period span in ticks
  localparam int RUNOUT_SPAN = 2000;   // run-out span in ms

  typedef enum logic [1:0] {
    REG_TICKS_PER_MS = 2'd0,
    REG_BUZZER_AFTER = 2'd1,
    REG_CUTOFF_AFTER = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              trig;
    logic [QUOT_W-1:0] half;
    logic [QUOT_W-1:0] runout_len;
  } strc_item_t;

endpackage

// File: rtl/core/strc_fsdiv.sv
// Scales a sample by a constant span and divides by the sample full scale.
module strc_fsdiv #(
  parameter int SAMPLE_BITS = 12,
  parameter int SPAN        = 2000
) (
  input  logic [SAMPLE_BITS-1:0]         sample,
  output logic [strc_pkg::QUOT_W-1:0]    quot
);

  localparam int SW = $clog2(SPAN + 1);
  localparam int XW = SAMPLE_BITS + SW;
  localparam int YW = XW + 1;
  localparam logic [YW-1:0] FS = YW'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [XW-1:0]               x;
  logic [YW-1:0]               y;
  logic [YW-1:0]               q0w;
  logic [YW-1:0]               rem;
  logic [strc_pkg::QUOT_W-1:0] q0;

  // x / (2^n - 1) ~ (x + x/2^n + x/2^2n) / 2^n, low by at most one
  always_comb begin
    x   = XW'(sample) * XW'(SPAN);
    y   = YW'(x) + YW'(x >> SAMPLE_BITS) + YW'(x >> (2 * SAMPLE_BITS));
    q0w = y >> SAMPLE_BITS;
    q0  = q0w[strc_pkg::QUOT_W-1:0];
    rem = YW'(x) - ((YW'(q0) << SAMPLE_BITS) - YW'(q0));
    quot = (rem >= FS) ? q0 + 1'b1 : q0;
  end

endmodule

// File: rtl/core/strc_scale.sv
// Input register and scaling stage: half period and run-out length per tick.
module strc_scale #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_trig,
  input  logic [SAMPLE_BITS-1:0]   in_speed,
  input  logic [SAMPLE_BITS-1:0]   in_runout,
  output logic                     item_valid,
  input  logic                     item_ready,
  output strc_pkg::strc_item_t     item
);

  logic                   v0;
  logic                   trig0;
  logic [SAMPLE_BITS-1:0] speed0;
  logic [SAMPLE_BITS-1:0] runout0;
  logic                   ld0;
  logic                   ld1;
  logic [strc_pkg::QUOT_W-1:0] speed_q;
  logic [strc_pkg::QUOT_W-1:0] runout_q;

  assign ld1      = !item_valid || item_ready;
  assign ld0      = !v0 || ld1;
  assign in_ready = ld0;

  strc_fsdiv #(.SAMPLE_BITS(SAMPLE_BITS), .SPAN(strc_pkg::SPEED_SPAN)) u_speed_div (
    .sample (speed0),
    .quot   (speed_q)
  );

  strc_fsdiv #(.SAMPLE_BITS(SAMPLE_BITS), .SPAN(strc_pkg::RUNOUT_SPAN)) u_runout_div (
    .sample (runout0),
    .quot   (runout_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0         <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (ld0) begin
        v0 <= in_valid;
      end
      if (ld1) begin
        item_valid <= v0;
      end
    end
    if (ld0 && in_valid) begin
      trig0   <= in_trig;
      speed0  <= in_speed;
      runout0 <= in_runout;
    end
    if (ld1 && v0) begin
      item.trig       <= trig0;
      item.half       <= speed_q + 1'b1;
      item.runout_len <= runout_q;
    end
  end

endmodule

// File: rtl/core/strc_ctrl.sv
// Trigger, safety and step state machine; its state registers form the result.
module strc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  strc_pkg::strc_item_t          item,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [strc_pkg::MS_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          step_pulse,
  output logic                          driver_disable,
  output logic                          solenoid_on,
  output logic                          buzzer_on,
  output logic [1:0]                    mode
);

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_RUN    = 2'd1,
    MODE_RUNOUT = 2'd2,
    MODE_CUT    = 2'd3
  } mode_t;

  localparam int QW = strc_pkg::QUOT_W;
  localparam int MW = strc_pkg::MS_W;
  localparam logic [QW-1:0] RUNOUT_SAT = '1;
  localparam logic [MW-1:0] HIGH_SAT   = '1;

  logic [MW-1:0] ticks_per_ms;
  logic [MW-1:0] buzzer_after_ms;
  logic [MW-1:0] cutoff_after_ms;

  mode_t         mode_reg,          mode_next;
  logic          prev_trigger,      prev_trigger_next;
  logic          lockout_flag,      lockout_flag_next;
  logic          buzzer_reg,        buzzer_reg_next;
  logic          solenoid_reg,      solenoid_reg_next;
  logic          disable_reg,       disable_reg_next;
  logic          step_level,        step_level_next;
  logic [QW-1:0] half_period_count, half_period_count_next;
  logic [MW-1:0] ms_prescale,       ms_prescale_next;
  logic [MW-1:0] high_time_ms,      high_time_ms_next;
  logic [QW-1:0] runout_elapsed_ms, runout_elapsed_ms_next;

  logic          fire;
  logic          rise;
  logic          fall;
  logic          ms_tick;
  logic [MW-1:0] tpm_last;
  logic [QW:0]   count_inc;

  assign item_ready = !out_valid || out_ready;
  assign fire       = item_valid && item_ready;

  assign step_pulse     = step_level;
  assign driver_disable = disable_reg;
  assign solenoid_on    = solenoid_reg;
  assign buzzer_on      = buzzer_reg;
  assign mode           = mode_reg;

  always_comb begin
    mode_next              = mode_reg;
    prev_trigger_next      = item.trig;
    lockout_flag_next      = lockout_flag;
    buzzer_reg_next        = buzzer_reg;
    solenoid_reg_next      = solenoid_reg;
    disable_reg_next       = disable_reg;
    step_level_next        = step_level;
    half_period_count_next = half_period_count;
    high_time_ms_next      = high_time_ms;
    runout_elapsed_ms_next = runout_elapsed_ms;
    count_inc              = '0;

    rise = item.trig && !prev_trigger;
    fall = !item.trig && prev_trigger;

    if (rise) begin
      high_time_ms_next = '0;
      if (!lockout_flag) begin
        disable_reg_next  = 1'b0;
        solenoid_reg_next = 1'b1;
        mode_next         = MODE_RUN;
      end
    end
    if (fall) begin
      buzzer_reg_next   = 1'b0;
      lockout_flag_next = 1'b0;
      if (mode_next == MODE_RUN) begin
        mode_next              = MODE_RUNOUT;
        runout_elapsed_ms_next = '0;
      end else if (mode_next == MODE_CUT) begin
        mode_next        = MODE_STOP;
        disable_reg_next = 1'b1;
      end
    end

    if (item.trig) begin
      if (high_time_ms_next >= buzzer_after_ms) begin
        buzzer_reg_next = 1'b1;
      end
      if (high_time_ms_next >= cutoff_after_ms && mode_next == MODE_RUN) begin
        mode_next         = MODE_CUT;
        lockout_flag_next = 1'b1;
        disable_reg_next  = 1'b1;
      end
    end

    if (mode_next == MODE_RUNOUT && runout_elapsed_ms_next >= item.runout_len) begin
      mode_next         = MODE_STOP;
      solenoid_reg_next = 1'b0;
      disable_reg_next  = 1'b1;
    end
    if (mode_next == MODE_RUN || mode_next == MODE_RUNOUT) begin
      if (half_period_count == '0) begin
        step_level_next = !step_level;
      end
      count_inc = {1'b0, half_period_count} + 1'b1;
      half_period_count_next = (count_inc >= {1'b0, item.half}) ? '0 : count_inc[QW-1:0];
    end else begin
      step_level_next        = 1'b0;
      half_period_count_next = '0;
    end

    // millisecond base, advanced on each accepted tick; zero period counts as one
    tpm_last         = (ticks_per_ms == '0) ? '0 : ticks_per_ms - 1'b1;
    ms_tick          = ms_prescale >= tpm_last;
    ms_prescale_next = ms_tick ? '0 : ms_prescale + 1'b1;
    if (ms_tick) begin
      if (item.trig && high_time_ms_next != HIGH_SAT) begin
        high_time_ms_next = high_time_ms_next + 1'b1;
      end
      if (mode_next == MODE_RUNOUT && runout_elapsed_ms_next != RUNOUT_SAT) begin
        runout_elapsed_ms_next = runout_elapsed_ms_next + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms      <= MW'(1000);
      buzzer_after_ms   <= MW'(6000);
      cutoff_after_ms   <= MW'(30000);
      out_valid         <= 1'b0;
      mode_reg          <= MODE_STOP;
      prev_trigger      <= 1'b0;
      lockout_flag      <= 1'b0;
      buzzer_reg        <= 1'b0;
      solenoid_reg      <= 1'b0;
      disable_reg       <= 1'b1;
      step_level        <= 1'b0;
      half_period_count <= '0;
      ms_prescale       <= '0;
      high_time_ms      <= '0;
      runout_elapsed_ms <= '0;
    end else begin
      if (cfg_we) begin
        unique case (strc_pkg::reg_idx_t'(cfg_index))
          strc_pkg::REG_TICKS_PER_MS: ticks_per_ms    <= cfg_data;
          strc_pkg::REG_BUZZER_AFTER: buzzer_after_ms <= cfg_data;
          strc_pkg::REG_CUTOFF_AFTER: cutoff_after_ms <= cfg_data;
          default: ;
        endcase
      end
      if (item_ready) begin
        out_valid <= item_valid;
      end
      if (fire) begin
        mode_reg          <= mode_next;
        prev_trigger      <= prev_trigger_next;
        lockout_flag      <= lockout_flag_next;
        buzzer_reg        <= buzzer_reg_next;
        solenoid_reg      <= solenoid_reg_next;
        disable_reg       <= disable_reg_next;
        step_level        <= step_level_next;
        half_period_count <= half_period_count_next;
        ms_prescale       <= ms_prescale_next;
        high_time_ms      <= high_time_ms_next;
        runout_elapsed_ms <= runout_elapsed_ms_next;
      end
    end
  end

endmodule

// File: rtl/core/stepper_trigger_runout_controller_core.sv
// Top level of the stepper trigger run-out controller.
// Path from input transaction to result transaction: input register,
// scaling register, state/result register. Each stage loads when empty or
// draining. Throughput: one tick per cycle while m_tready does not stall.
// Reset (rst, synchronous): pipeline empty, mode stopped, driver disabled,
// configuration back to 1000 ticks/ms, buzzer 6000 ms, cutoff 30000 ms.
module stepper_trigger_runout_controller_core #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // trigger_level, speed_level, runout_level, zero pad
  input  logic [((1 + 2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // step_pulse, driver_disable, solenoid_on, buzzer_on, mode[1:0], zero pad
  output logic [7:0]          m_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic                 item_valid;
  logic                 item_ready;
  strc_pkg::strc_item_t item;
  logic                 step_pulse;
  logic                 driver_disable;
  logic                 solenoid_on;
  logic                 buzzer_on;
  logic [1:0]           mode;

  strc_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_trig    (s_tdata[0]),
    .in_speed   (s_tdata[SAMPLE_BITS:1]),
    .in_runout  (s_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1]),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  strc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .step_pulse     (step_pulse),
    .driver_disable (driver_disable),
    .solenoid_on    (solenoid_on),
    .buzzer_on      (buzzer_on),
    .mode           (mode)
  );

  assign m_tdata = {2'b00, mode, buzzer_on, solenoid_on, driver_disable, step_pulse};

endmodule

// File: sim/stepper_trigger_runout_controller_core_test.sv
// Self-checking testbench for the stepper trigger run-out controller core.
module stepper_trigger_runout_controller_core_test;

  localparam int SAMPLE_BITS  = 12;
  localparam int FULL_SCALE   = (1 << SAMPLE_BITS) - 1;
  localparam int IN_W         = ((1 + 2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int RUNOUT_SAT   = (1 << strc_pkg::QUOT_W) - 1;
  localparam int HIGH_SAT     = (1 << strc_pkg::MS_W) - 1;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_RUNOUT  = 2'd2,
    MODE_CUTOFF  = 2'd3
  } motor_mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic       buzzer;
    logic       solenoid;
    logic       drv_off;
    logic       step;
  } ctrl_out_t;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata;
  logic            m_tvalid;
  logic            m_tready;
  logic [7:0]      m_tdata;
  logic            cfg_we;
  logic [1:0]      cfg_index;
  logic [15:0]     cfg_data;

  stepper_trigger_runout_controller_core #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // controller copy
  logic [strc_pkg::MS_W-1:0]   tick_rate_reg;
  logic [strc_pkg::MS_W-1:0]   buzzer_limit_ms;
  logic [strc_pkg::MS_W-1:0]   cutoff_limit_ms;
  motor_mode_e                 mode_st;
  logic                        trig_prev;
  logic                        lockout;
  logic                        buzzer_st;
  logic                        solenoid_st;
  logic                        drv_off_st;
  logic                        step_st;
  logic [strc_pkg::QUOT_W-1:0] half_cnt;
  logic [strc_pkg::MS_W-1:0]   prescale;
  logic [strc_pkg::MS_W-1:0]   high_ms;
  logic [strc_pkg::QUOT_W-1:0] runout_ms;

  ctrl_out_t expected_outputs[$];
  int        mismatch_count;
  int        items_sent;
  int        gap_max;
  int        stall_max;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("stepper_trigger_runout_controller_core_test NOT OK");
    $finish;
  end

  task automatic reset_controller_copy();
    tick_rate_reg   = 16'd1000;
    buzzer_limit_ms = 16'd6000;
    cutoff_limit_ms = 16'd30000;
    mode_st     = MODE_STOPPED;
    trig_prev   = 1'b0;
    lockout     = 1'b0;
    buzzer_st   = 1'b0;
    solenoid_st = 1'b0;
    drv_off_st  = 1'b1;
    step_st     = 1'b0;
    half_cnt    = '0;
    prescale    = '0;
    high_ms     = '0;
    runout_ms   = '0;
  endtask

  function automatic ctrl_out_t advance_tick(logic trig, logic [SAMPLE_BITS-1:0] spd,
                                             logic [SAMPLE_BITS-1:0] ro);
    int        half;
    int        runout_len;
    int        tpm;
    bit        ms_tick;
    ctrl_out_t r;
    half       = 1 + (int'(spd) * strc_pkg::SPEED_SPAN) / FULL_SCALE;
    runout_len = (int'(ro) * strc_pkg::RUNOUT_SPAN) / FULL_SCALE;
    tpm        = (tick_rate_reg == 0) ? 1 : int'(tick_rate_reg);

    if (trig && !trig_prev) begin
      high_ms = '0;
      if (!lockout) begin
        drv_off_st  = 1'b0;
        solenoid_st = 1'b1;
        mode_st     = MODE_RUNNING;
      end
    end
    if (!trig && trig_prev) begin
      buzzer_st = 1'b0;
      lockout   = 1'b0;
      if (mode_st == MODE_RUNNING) begin
        mode_st   = MODE_RUNOUT;
        runout_ms = '0;
      end else if (mode_st == MODE_CUTOFF) begin
        mode_st    = MODE_STOPPED;
        drv_off_st = 1'b1;
      end
    end
    trig_prev = trig;

    if (trig) begin
      if (high_ms >= buzzer_limit_ms) buzzer_st = 1'b1;
      if (high_ms >= cutoff_limit_ms && mode_st == MODE_RUNNING) begin
        mode_st    = MODE_CUTOFF;
        lockout    = 1'b1;
        drv_off_st = 1'b1;
      end
    end

    if (mode_st == MODE_RUNOUT && int'(runout_ms) >= runout_len) begin
      mode_st     = MODE_STOPPED;
      solenoid_st = 1'b0;
      drv_off_st  = 1'b1;
    end
    if (mode_st == MODE_RUNNING || mode_st == MODE_RUNOUT) begin
      if (half_cnt == 0) step_st = ~step_st;
      half_cnt = half_cnt + 1'b1;
      if (int'(half_cnt) >= half) half_cnt = '0;
    end else begin
      step_st  = 1'b0;
      half_cnt = '0;
    end

    ms_tick  = int'(prescale) >= tpm - 1;
    prescale = ms_tick ? '0 : prescale + 1'b1;
    if (ms_tick) begin
      if (trig && int'(high_ms) < HIGH_SAT) high_ms = high_ms + 1'b1;
      if (mode_st == MODE_RUNOUT && int'(runout_ms) < RUNOUT_SAT) runout_ms = runout_ms + 1'b1;
    end

    r.step     = step_st;
    r.drv_off  = drv_off_st;
    r.solenoid = solenoid_st;
    r.buzzer   = buzzer_st;
    r.mode     = mode_st;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      expected_outputs.push_back(advance_tick(s_tdata[0], s_tdata[SAMPLE_BITS:1],
                                              s_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1]));
  end

  always @(posedge clk) begin
    ctrl_out_t want;
    ctrl_out_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[5:0];
      if (expected_outputs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result with no pending tick: %h", m_tdata);
      end else begin
        want = expected_outputs.pop_front();
        if (got.step !== want.step || got.drv_off !== want.drv_off ||
            got.solenoid !== want.solenoid || got.buzzer !== want.buzzer ||
            got.mode !== want.mode) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch exp %b %b %b %b %0d got %b %b %b %b %0d",
                     want.step, want.drv_off, want.solenoid, want.buzzer, want.mode,
                     got.step, got.drv_off, got.solenoid, got.buzzer, got.mode);
        end
      end
    end
  end

  // result side backpressure
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      stall = $urandom_range(0, stall_max);
      @(negedge clk);
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_tick(logic trig, logic [SAMPLE_BITS-1:0] spd,
                           logic [SAMPLE_BITS-1:0] ro);
    int gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = IN_W'({ro, spd, trig});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(strc_pkg::reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      strc_pkg::REG_TICKS_PER_MS: tick_rate_reg   = val;
      strc_pkg::REG_BUZZER_AFTER: buzzer_limit_ms = val;
      strc_pkg::REG_CUTOFF_AFTER: cutoff_limit_ms = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] tpm, logic [15:0] buzz, logic [15:0] cut);
    wait_idle();
    write_reg(strc_pkg::REG_TICKS_PER_MS, tpm);
    write_reg(strc_pkg::REG_BUZZER_AFTER, buzz);
    write_reg(strc_pkg::REG_CUTOFF_AFTER, cut);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_speed();
    case ($urandom_range(0, 3))
      0: return SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
      1: return $urandom_range(0, 1) ? SAMPLE_BITS'(FULL_SCALE) : '0;
      default: return SAMPLE_BITS'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_runout();
    case ($urandom_range(0, 7))
      0: return SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
      1: return '0;
      default: return SAMPLE_BITS'($urandom_range(0, 120));
    endcase
  endfunction

  // one trigger pull and release, samples drifting now and then
  task automatic send_run(int high_len, int low_len);
    logic [SAMPLE_BITS-1:0] spd;
    logic [SAMPLE_BITS-1:0] ro;
    spd = pick_speed();
    ro  = pick_runout();
    repeat (high_len) begin
      if ($urandom_range(0, 15) == 0) spd = pick_speed();
      send_tick(1'b1, spd, ro);
    end
    repeat (low_len) begin
      if ($urandom_range(0, 15) == 0) spd = pick_speed();
      if ($urandom_range(0, 31) == 0) ro = pick_runout();
      send_tick(1'b0, spd, ro);
    end
  endtask

  task automatic send_noise(int count);
    repeat (count)
      send_tick(1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom_range(0, FULL_SCALE)),
                SAMPLE_BITS'($urandom_range(0, FULL_SCALE)));
  endtask

  task automatic test_directed_edges();
    configure(16'd1, 16'd2, 16'd4);
    send_tick(1'b0, SAMPLE_BITS'(FULL_SCALE), SAMPLE_BITS'(FULL_SCALE));
    repeat (6) send_tick(1'b1, 0, 0);         // buzzer, then cutoff with lockout
    send_tick(1'b0, 2048, 0);                 // leave cutoff, solenoid kept
    repeat (3) send_tick(1'b1, SAMPLE_BITS'(FULL_SCALE), 0);
    send_tick(1'b0, SAMPLE_BITS'(FULL_SCALE), 0);   // zero run-out stops at once
    send_tick(1'b1, 1, SAMPLE_BITS'(FULL_SCALE));
    repeat (4) send_tick(1'b0, 1, SAMPLE_BITS'(FULL_SCALE));
    send_tick(1'b1, 2100, SAMPLE_BITS'(FULL_SCALE));  // restart out of run-out
    send_tick(1'b1, 0, SAMPLE_BITS'(FULL_SCALE));     // half period below count
    repeat (6) send_tick(1'b0, 0, 10);
  endtask

  task automatic test_zero_limits();
    configure(16'd0, 16'd0, 16'd0);
    send_tick(1'b1, 100, 50);
    send_tick(1'b1, 100, 50);
    send_tick(1'b0, 100, 50);
    repeat (3) send_run($urandom_range(1, 10), $urandom_range(1, 10));
  endtask

  task automatic test_lowered_prescale();
    configure(16'd1000, 16'd65535, 16'd65535);
    repeat (3) send_run($urandom_range(20, 40), $urandom_range(10, 20));
    wait_idle();
    write_reg(strc_pkg::REG_TICKS_PER_MS, 16'd5);
    repeat (3) send_run($urandom_range(1, 40), $urandom_range(1, 60));
  endtask

  task automatic test_random_sessions();
    int start;
    int high_len;
    int low_len;
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: configure(16'd1, 16'($urandom_range(0, 20)), 16'($urandom_range(0, 60)));
        1: configure(16'd2, 16'($urandom_range(0, 30)), 16'($urandom_range(0, 40)));
        2: configure(16'd3, 16'd65535, 16'($urandom_range(0, 30)));
        3: configure(16'd65535, 16'd0, 16'd0);
        4: configure(16'd0, 16'($urandom_range(0, 10)), 16'd65535);
        5: configure(16'd1, 16'($urandom_range(0, 100)), 16'($urandom_range(0, 200)));
        6: configure(16'($urandom_range(1, 4)), 16'($urandom_range(0, 20)),
                     16'($urandom_range(0, 50)));
        default: configure(16'd1, 16'd0, 16'($urandom_range(0, 10)));
      endcase
      gap_max   = $urandom_range(0, 2) != 0 ? 12 : 0;
      stall_max = $urandom_range(0, 2) != 0 ? 12 : 0;
      start = items_sent;
      while (items_sent - start < 40) begin
        if ($urandom_range(0, 9) == 0) begin
          send_noise($urandom_range(1, 20));
        end else begin
          high_len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 200) : $urandom_range(1, 40);
          low_len  = $urandom_range(0, 39) == 0 ? $urandom_range(1, 2100) : $urandom_range(1, 40);
          send_run(high_len, low_len);
        end
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
    end
    gap_max   = 12;
    stall_max = 12;
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_we         = 1'b0;
    cfg_index      = strc_pkg::REG_TICKS_PER_MS;
    cfg_data       = '0;
    gap_max        = 12;
    stall_max      = 12;
    mismatch_count = 0;
    items_sent     = 0;
    reset_controller_copy();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_directed_edges();
    test_zero_limits();
    test_lowered_prescale();
    test_random_sessions();
    wait_idle();

    if (mismatch_count == 0 && expected_outputs.size() == 0) begin
      $display("stepper_trigger_runout_controller_core_test OK");
    end else begin
      $display("stepper_trigger_runout_controller_core_test NOT OK");
    end
    $finish;
  end

endmodule

// File: stepper_trigger_runout_controller_core.f
rtl/core/strc_pkg.sv
rtl/core/strc_fsdiv.sv
rtl/core/strc_scale.sv
rtl/core/strc_ctrl.sv
rtl/core/stepper_trigger_runout_controller_core.sv
sim/stepper_trigger_runout_controller_core_test.sv
